### rtl/core/hcr_pkg.sv
package hcr_pkg;

	localparam int AMP_W      = 15;
	localparam int SPREAD_W   = 16;
	localparam int COLOR_W    = 24;
	localparam int CH_W       = 8;
	localparam int STOP_COUNT = 5;
	localparam int STOP_IDX_W = 3;
	localparam int BLEND_BITS = 14;
	localparam int Q_BITS     = 16;
	localparam int PROD_W     = AMP_W + SPREAD_W;
	localparam int DEN_W      = PROD_W + 1;
	localparam int FRONT_STAGES = 3;
	localparam int BLEND_STAGES = 2;

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = COLOR_W;

	localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPREAD    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STOP_0    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STOP_1    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STOP_2    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STOP_3    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_STOP_4    = 3'd6;

	localparam logic [AMP_W-1:0]    AMPLITUDE_RST = 15'd2560;
	localparam logic [SPREAD_W-1:0] SPREAD_RST    = 16'd7373;
	localparam logic [COLOR_W-1:0]  STOP_0_RST    = 24'hC9B263;
	localparam logic [COLOR_W-1:0]  STOP_1_RST    = 24'h87B852;
	localparam logic [COLOR_W-1:0]  STOP_2_RST    = 24'h50AB5D;
	localparam logic [COLOR_W-1:0]  STOP_3_RST    = 24'h787878;
	localparam logic [COLOR_W-1:0]  STOP_4_RST    = 24'hC8C8C8;

	typedef logic [STOP_COUNT-1:0][COLOR_W-1:0] hcr_stops_t;

	typedef struct packed {
		logic             neg;
		logic             over;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
	} hcr_div_in_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} hcr_rgb_t;

endpackage

### rtl/core/hcr_front.sv
module hcr_front import hcr_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [HEIGHT_BITS-1:0] height,
	input  logic [AMP_W-1:0]              amplitude,
	input  logic [SPREAD_W-1:0]           spread,
	output logic                          out_vld,
	output hcr_div_in_t                   out_dat
);

	localparam int SUM_W = ((HEIGHT_BITS > AMP_W + 1) ? HEIGHT_BITS : AMP_W + 1) + 1;
	localparam int N_W   = SUM_W + BLEND_BITS + 2;

	logic [AMP_W-1:0]    a_eff;
	logic [SPREAD_W-1:0] s_eff;
	logic signed [SUM_W-1:0] h_ext;
	logic signed [SUM_W-1:0] a_ext;

	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [SUM_W-1:0] hsum_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic signed [N_W-1:0]   num_s2;
	logic [DEN_W-1:0]        den_s2;
	hcr_div_in_t             dat_s3;

	logic signed [N_W-1:0] hsum_sh;
	logic signed [N_W-1:0] prod_ext;
	logic signed [N_W-1:0] den_ext;
	logic                  neg_c;

	// zero amplitude or spread acts as one LSB
	assign a_eff = (amplitude == '0) ? AMP_W'(1) : amplitude;
	assign s_eff = (spread == '0) ? SPREAD_W'(1) : spread;
	assign h_ext = SUM_W'(height);
	assign a_ext = SUM_W'(a_eff);

	assign hsum_sh  = N_W'(hsum_s1) <<< BLEND_BITS;
	assign prod_ext = N_W'(prod_s1);
	assign den_ext  = N_W'(den_s2);
	assign neg_c    = num_s2[N_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		hsum_s1 <= h_ext + a_ext;
		prod_s1 <= PROD_W'(a_eff) * PROD_W'(s_eff);
		num_s2  <= hsum_sh - prod_ext;
		den_s2  <= {prod_s1, 1'b0};
		dat_s3  <= '{
			neg:  neg_c,
			over: !neg_c && (num_s2 >= den_ext),
			rem:  num_s2[DEN_W-1:0],
			den:  den_s2
		};
	end

	assign out_vld = vld_s3;
	assign out_dat = dat_s3;

endmodule

### rtl/core/hcr_divider.sv
module hcr_divider import hcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  hcr_div_in_t       in_dat,
	output logic              out_vld,
	output logic [Q_BITS-1:0] out_q
);

	logic              vld_s [1:Q_BITS];
	hcr_div_in_t       dat_s [1:Q_BITS];
	logic [Q_BITS-1:0] quo_s [1:Q_BITS];

	for (genvar k = 0; k < Q_BITS; k++) begin : g_step
		logic              cur_vld;
		hcr_div_in_t       cur;
		logic [Q_BITS-1:0] cur_q;
		logic [DEN_W:0]    r2;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_vld = in_vld;
			assign cur     = in_dat;
			assign cur_q   = '0;
		end else begin : g_next
			assign cur_vld = vld_s[k];
			assign cur     = dat_s[k];
			assign cur_q   = quo_s[k];
		end

		assign r2   = {cur.rem, 1'b0};
		assign diff = r2 - {1'b0, cur.den};
		assign ge   = (r2 >= {1'b0, cur.den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			dat_s[k+1] <= '{
				neg:  cur.neg,
				over: cur.over,
				rem:  ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0],
				den:  cur.den
			};
			quo_s[k+1] <= {cur_q[Q_BITS-2:0], ge};
		end
	end

	assign out_vld = vld_s[Q_BITS];
	assign out_q   = dat_s[Q_BITS].neg  ? '0 :
	                 dat_s[Q_BITS].over ? '1 : quo_s[Q_BITS];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld && !in_dat.neg && !in_dat.over |-> in_dat.rem < in_dat.den)
		else $error("divider entry remainder not below divisor");

	a_neg_over_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> !(in_dat.neg && in_dat.over))
		else $error("negative and saturated flags both set");

	a_valid_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld == $past(in_vld, Q_BITS))
		else $error("divider valid lost or invented");

endmodule

### rtl/core/hcr_blend.sv
module hcr_blend import hcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [Q_BITS-1:0] in_q,
	input  hcr_stops_t        stops,
	output logic              out_vld,
	output hcr_rgb_t          out_rgb
);

	logic [1:0]            seg;
	logic [STOP_IDX_W-1:0] lo_idx;
	logic [STOP_IDX_W-1:0] hi_idx;

	logic                  vld_s1, vld_s2;
	logic [COLOR_W-1:0]    lo_s1, hi_s1;
	logic [BLEND_BITS-1:0] w_s1;
	hcr_rgb_t              rgb_s2;

	logic [CH_W-1:0] ch_c [3];

	assign seg    = in_q[Q_BITS-1 -: 2];
	assign lo_idx = STOP_IDX_W'(seg);
	assign hi_idx = lo_idx + STOP_IDX_W'(1);

	// lo + floor((hi - lo) * w / 2^14)
	always_comb begin
		logic signed [CH_W:0]             diff;
		logic signed [BLEND_BITS:0]       wt;
		logic signed [CH_W+BLEND_BITS+1:0] acc;
		for (int c = 0; c < 3; c++) begin
			diff = $signed({1'b0, hi_s1[c*CH_W +: CH_W]})
			     - $signed({1'b0, lo_s1[c*CH_W +: CH_W]});
			wt   = $signed({1'b0, w_s1});
			acc  = $signed({2'b00, lo_s1[c*CH_W +: CH_W], {BLEND_BITS{1'b0}}})
			     + (CH_W+BLEND_BITS+2)'(diff) * (CH_W+BLEND_BITS+2)'(wt);
			ch_c[c] = acc[BLEND_BITS +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1  <= stops[lo_idx];
		hi_s1  <= stops[hi_idx];
		w_s1   <= in_q[BLEND_BITS-1:0];
		rgb_s2 <= '{red: ch_c[2], green: ch_c[1], blue: ch_c[0]};
	end

	assign out_vld = vld_s2;
	assign out_rgb = rgb_s2;

endmodule

### rtl/core/height_to_color_ramp_unit.sv
// channel  | dir | signals                          | transfer
// sample   | in  | start, busy, height              | start && !busy at clk rise
// color    | out | done, red, green, blue           | done high for one cycle
// config   | in  | cfg_we, cfg_index, cfg_data      | cfg_we at clk rise
//
// One sample per cycle; busy stays low. Pipeline: 3 front stages
// (product, numerator, range check), 16 restoring divider stages at one
// quotient bit each, 2 blend stages (stop select, multiply-add).
// arst_n clears all valid bits and loads the default registers.
// The color side cannot stall; results leave the pipeline as they finish.
module height_to_color_ramp_unit import hcr_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [HEIGHT_BITS-1:0] height,
	output logic                          done,
	output logic [CH_W-1:0]               red,
	output logic [CH_W-1:0]               green,
	output logic [CH_W-1:0]               blue,
	input  logic                          cfg_we,
	input  logic [REG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int LATENCY = FRONT_STAGES + Q_BITS + BLEND_STAGES;

	logic [AMP_W-1:0]    amplitude_q;
	logic [SPREAD_W-1:0] spread_q;
	hcr_stops_t          stops_q;

	logic              accept;
	logic              front_vld;
	hcr_div_in_t       front_dat;
	logic              div_vld;
	logic [Q_BITS-1:0] div_q;
	logic              blend_vld;
	hcr_rgb_t          blend_rgb;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMPLITUDE_RST;
			spread_q    <= SPREAD_RST;
			stops_q     <= {STOP_4_RST, STOP_3_RST, STOP_2_RST, STOP_1_RST, STOP_0_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AMPLITUDE: amplitude_q <= cfg_data[AMP_W-1:0];
				REG_SPREAD:    spread_q    <= cfg_data[SPREAD_W-1:0];
				REG_STOP_0:    stops_q[0]  <= cfg_data;
				REG_STOP_1:    stops_q[1]  <= cfg_data;
				REG_STOP_2:    stops_q[2]  <= cfg_data;
				REG_STOP_3:    stops_q[3]  <= cfg_data;
				REG_STOP_4:    stops_q[4]  <= cfg_data;
				default: ;
			endcase
		end
	end

	hcr_front #(
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (accept),
		.height   (height),
		.amplitude(amplitude_q),
		.spread   (spread_q),
		.out_vld  (front_vld),
		.out_dat  (front_dat)
	);

	hcr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (front_vld),
		.in_dat (front_dat),
		.out_vld(div_vld),
		.out_q  (div_q)
	);

	hcr_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (div_vld),
		.in_q   (div_q),
		.stops  (stops_q),
		.out_vld(blend_vld),
		.out_rgb(blend_rgb)
	);

	assign done  = blend_vld;
	assign red   = blend_rgb.red;
	assign green = blend_rgb.green;
	assign blue  = blend_rgb.blue;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted sample gave no result");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted sample");

	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) ##1 (start && !busy) |-> ##(LATENCY - 1) done ##1 done)
		else $error("consecutive samples not delivered consecutively");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import hcr_pkg::*;

	localparam int H_W = 16;
	localparam int LIMIT = 300000;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	class color_ramp_checker;
		logic [AMP_W-1:0]    amplitude;
		logic [SPREAD_W-1:0] spread;
		logic [COLOR_W-1:0]  stops [STOP_COUNT];
		hcr_rgb_t            colors_due [$];
		int                  errors;

		function new();
			amplitude = AMPLITUDE_RST;
			spread    = SPREAD_RST;
			stops[0]  = STOP_0_RST;
			stops[1]  = STOP_1_RST;
			stops[2]  = STOP_2_RST;
			stops[3]  = STOP_3_RST;
			stops[4]  = STOP_4_RST;
			errors    = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_AMPLITUDE: amplitude = data[AMP_W-1:0];
				REG_SPREAD:    spread = data[SPREAD_W-1:0];
				REG_STOP_0:    stops[0] = data;
				REG_STOP_1:    stops[1] = data;
				REG_STOP_2:    stops[2] = data;
				REG_STOP_3:    stops[3] = data;
				REG_STOP_4:    stops[4] = data;
				default: ;
			endcase
		endfunction

		function hcr_rgb_t ramp_color(logic signed [H_W-1:0] h);
			longint hv, a, s, num, den, q;
			int seg, w, k, lo, hi;
			logic [CH_W-1:0] ch [3];
			hcr_rgb_t c;
			hv = h;
			a = (amplitude != 0) ? longint'(amplitude) : 1;
			s = (spread != 0) ? longint'(spread) : 1;
			num = ((hv + a) * 16384 - a * s) * 65536;
			den = 2 * a * s;
			if (num < 0) begin
				q = 0;
			end else begin
				q = num / den;
				if (q > 65535)
					q = 65535;
			end
			seg = int'(q >> BLEND_BITS);
			w = int'(q & 64'h3FFF);
			for (k = 0; k < 3; k++) begin
				lo = int'(stops[seg][16-8*k +: 8]);
				hi = int'(stops[seg+1][16-8*k +: 8]);
				ch[k] = 8'((lo * (16384 - w) + hi * w) >> BLEND_BITS);
			end
			c.red = ch[0];
			c.green = ch[1];
			c.blue = ch[2];
			return c;
		endfunction

		function void note_height(logic signed [H_W-1:0] h);
			colors_due.push_back(ramp_color(h));
		endfunction

		function int pending();
			return colors_due.size();
		endfunction

		task report(string msg);
			$display("%t color check: %s", $realtime, msg);
			errors++;
		endtask

		task check_color(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			hcr_rgb_t e;
			if (colors_due.size() == 0) begin
				report($sformatf("unexpected color %h %h %h", r, g, b));
			end else begin
				e = colors_due.pop_front();
				if (r !== e.red)
					report($sformatf("red exp %h got %h", e.red, r));
				if (g !== e.green)
					report($sformatf("green exp %h got %h", e.green, g));
				if (b !== e.blue)
					report($sformatf("blue exp %h got %h", e.blue, b));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic signed [H_W-1:0] height;
	logic                  done;
	logic [CH_W-1:0]       red;
	logic [CH_W-1:0]       green;
	logic [CH_W-1:0]       blue;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	color_ramp_checker ramp_chk = new();
	int cycle_count;

	height_to_color_ramp_unit #(
		.HEIGHT_BITS(H_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.height(height),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			ramp_chk.check_color(red, green, blue);
	end

	initial begin
		for (cycle_count = 0; cycle_count < LIMIT; cycle_count++)
			@(posedge clk);
		$display("tb: errors");
		$finish;
	end

	function automatic logic signed [H_W-1:0] clamp_height(longint h);
		if (h > 32767)
			h = 32767;
		if (h < -32768)
			h = -32768;
		return H_W'(h);
	endfunction

	function automatic longint eff_amplitude();
		return (ramp_chk.amplitude != 0) ? longint'(ramp_chk.amplitude) : 1;
	endfunction

	// height landing near ramp position v (Q0.16) under the current setting
	function automatic logic signed [H_W-1:0] height_for(longint v, int jit);
		longint a, s, h;
		a = eff_amplitude();
		s = (ramp_chk.spread != 0) ? longint'(ramp_chk.spread) : 1;
		h = ((a * (2 * v + 65536) * s) >>> 30) - a + jit;
		return clamp_height(h);
	endfunction

	function automatic logic signed [H_W-1:0] pick_height();
		int sel;
		longint a;
		sel = $urandom_range(0, 99);
		a = eff_amplitude();
		if (sel < 60)
			return height_for(longint'($urandom_range(0, 65535)), int'($urandom_range(0, 4)) - 2);
		else if (sel < 85)
			return clamp_height(longint'($urandom_range(0, 2 * int'(a))) - a);
		else
			return H_W'($urandom);
	endfunction

	task automatic send_height(input logic signed [H_W-1:0] h, input int idle_pct);
		int gap;
		@(negedge clk);
		start = 1;
		height = h;
		do @(posedge clk); while (busy);
		ramp_chk.note_height(h);
		if (int'($urandom_range(0, 99)) < idle_pct) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			start = 0;
			height = H_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 0;
		while (ramp_chk.pending() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		ramp_chk.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic program_ramp(input logic [AMP_W-1:0] a, input logic [SPREAD_W-1:0] s,
			input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1,
			input logic [COLOR_W-1:0] c2, input logic [COLOR_W-1:0] c3,
			input logic [COLOR_W-1:0] c4);
		// upper data bits are don't-care for the narrow registers
		cfg_write(REG_AMPLITUDE, {9'($urandom), a});
		cfg_write(REG_SPREAD, {8'($urandom), s});
		cfg_write(REG_STOP_0, c0);
		cfg_write(REG_STOP_1, c1);
		cfg_write(REG_STOP_2, c2);
		cfg_write(REG_STOP_3, c3);
		cfg_write(REG_STOP_4, c4);
		cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
	endtask

	task automatic set_phase(input int p);
		case (p)
			1: program_ramp(15'd1, 16'd1, 24'h000000, 24'hFFFFFF, 24'h000000,
				24'hFFFFFF, 24'h000000);
			2: program_ramp(15'd32767, 16'd65535, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
				24'h000000, 24'hFFFFFF);
			3: program_ramp(15'd0, 16'd0, 24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom));
			4: program_ramp(15'd32767, 16'd1, 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 24'($urandom));
			5: program_ramp(15'd1, 16'd65535, 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 24'($urandom));
			default: program_ramp(15'($urandom), 16'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		endcase
	endtask

	initial begin
		int p, pct;
		start = 0;
		height = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// field extremes, ramp ends, segment edges
		send_height(16'sh8000, 0);
		send_height(16'sh7FFF, 0);
		send_height(16'sh0000, 0);
		send_height(-16'sd1, 30);
		send_height(16'sd1, 0);
		send_height(-16'sd2560, 0);
		send_height(16'sd2560, 30);
		send_height(16'sh5555, 0);
		send_height(16'shAAAA, 0);
		send_height(height_for(0, 0), 0);
		send_height(height_for(1, 0), 30);
		send_height(height_for(16383, 0), 0);
		send_height(height_for(16384, 0), 0);
		send_height(height_for(32767, 0), 0);
		send_height(height_for(32768, 0), 30);
		send_height(height_for(49151, 0), 0);
		send_height(height_for(49152, 0), 0);
		send_height(height_for(65534, 0), 0);
		send_height(height_for(65535, 0), 0);

		for (p = 0; p < 10; p++) begin
			if (p > 0) begin
				drain();
				set_phase(p);
			end
			pct = (p == 9) ? 0 : $urandom_range(0, 60);
			repeat (p == 0 ? 130 : 135)
				send_height(pick_height(), pct);
		end

		drain();
		repeat (40) @(posedge clk);
		if (ramp_chk.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

### sim.f
rtl/core/hcr_pkg.sv
rtl/core/hcr_front.sv
rtl/core/hcr_divider.sv
rtl/core/hcr_blend.sv
rtl/core/height_to_color_ramp_unit.sv
tb/tb.sv
